/* hdl/tnt_pkg.sv */
package tnt_pkg;

	localparam int COORD_W  = 16;
	localparam int UV_W     = 16;
	localparam int NORM_W   = 34;
	localparam int TAN_W    = 32;
	localparam int UV_FRAC  = 12;
	localparam int DW       = COORD_W + 1;
	localparam int TW       = UV_W + 1;
	localparam int NPW      = 2 * DW + 1;
	localparam int PW       = DW + TW + 1;
	localparam int DETW     = 2 * TW + 1;
	localparam int DIVW     = PW + UV_FRAC + 1;
	localparam int CNT_W    = $clog2(DIVW + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_EN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TANGENT_EN = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic signed [UV_W-1:0] u;
		logic signed [UV_W-1:0] v;
	} uv_t;

	typedef struct packed {
		pos_t p0;
		pos_t p1;
		pos_t p2;
		uv_t  t0;
		uv_t  t1;
		uv_t  t2;
	} tri_t;

	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [NPW-1:0] v);
		logic signed [NPW-1:0] hi;
		logic signed [NPW-1:0] lo;
		hi = NPW'((64'sd1 <<< (NORM_W - 1)) - 64'sd1);
		lo = -hi - NPW'(1);
		if (v > hi)
			sat_norm = NORM_W'(hi);
		else if (v < lo)
			sat_norm = NORM_W'(lo);
		else
			sat_norm = NORM_W'(v);
	endfunction

endpackage

/* hdl/tnt_vtx_if.sv */
interface tnt_vtx_if;
	logic                                valid;
	logic                                ready;
	logic signed [tnt_pkg::COORD_W-1:0]  pos_x;
	logic signed [tnt_pkg::COORD_W-1:0]  pos_y;
	logic signed [tnt_pkg::COORD_W-1:0]  pos_z;
	logic signed [tnt_pkg::UV_W-1:0]     tex_u;
	logic signed [tnt_pkg::UV_W-1:0]     tex_v;
	logic                                restart;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, restart, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, restart, output ready);
endinterface

/* hdl/tnt_res_if.sv */
interface tnt_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [tnt_pkg::NORM_W-1:0]  normal_x;
	logic signed [tnt_pkg::NORM_W-1:0]  normal_y;
	logic signed [tnt_pkg::NORM_W-1:0]  normal_z;
	logic signed [tnt_pkg::TAN_W-1:0]   tangent_x;
	logic signed [tnt_pkg::TAN_W-1:0]   tangent_y;
	logic signed [tnt_pkg::TAN_W-1:0]   tangent_z;
	logic                               degenerate_uv;

	modport source (output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
		tangent_z, degenerate_uv, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
		tangent_z, degenerate_uv, output ready);
endinterface

/* hdl/tnt_cfg_if.sv */
interface tnt_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tnt_pkg::CFG_IDX_W-1:0]       index;
	logic [31:0]                         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/tnt_front.sv */
module tnt_front (
	input  logic           clk,
	input  logic           arst_n,
	tnt_vtx_if.sink        vtx,
	output logic           q_valid,
	input  logic           q_ready,
	output tnt_pkg::tri_t  q_data
);
	import tnt_pkg::*;

	logic [1:0] slot_q;
	logic [1:0] slot_eff;
	logic       accept;
	pos_t       hold_pos_q [2];
	uv_t        hold_uv_q [2];
	pos_t       cur_pos;
	uv_t        cur_uv;

	assign vtx.ready = q_ready;
	assign accept    = vtx.valid && vtx.ready;
	assign slot_eff  = vtx.restart ? 2'd0 : slot_q;
	assign cur_pos   = '{x: vtx.pos_x, y: vtx.pos_y, z: vtx.pos_z};
	assign cur_uv    = '{u: vtx.tex_u, v: vtx.tex_v};

	assign q_valid     = accept && (slot_eff == 2'd2);
	assign q_data.p0   = hold_pos_q[0];
	assign q_data.p1   = hold_pos_q[1];
	assign q_data.p2   = cur_pos;
	assign q_data.t0   = hold_uv_q[0];
	assign q_data.t1   = hold_uv_q[1];
	assign q_data.t2   = cur_uv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
		end else if (accept) begin
			if (slot_eff == 2'd2)
				slot_q <= 2'd0;
			else
				slot_q <= slot_eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && slot_eff != 2'd2) begin
			hold_pos_q[slot_eff[0]] <= cur_pos;
			hold_uv_q[slot_eff[0]]  <= cur_uv;
		end
	end
endmodule

/* hdl/tnt_fifo.sv */
module tnt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  tnt_pkg::tri_t  wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output tnt_pkg::tri_t  rd_data
);
	import tnt_pkg::*;

	tri_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end
endmodule

/* hdl/tnt_back.sv */
module tnt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           normal_en,
	input  logic           tangent_en,
	input  logic           q_valid,
	output logic           q_ready,
	input  tnt_pkg::tri_t  q_data,
	tnt_res_if.source      res
);
	import tnt_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_LOAD, S_DIV, S_FIN, S_OUT} state_t;

	state_t                   state_q;
	logic signed [DW-1:0]     b_q [3];
	logic signed [DW-1:0]     a_q [3];
	logic signed [TW-1:0]     du1_q, dv1_q, du2_q, dv2_q;
	logic signed [2*DW-1:0]   np_q [6];
	logic signed [DW+TW-1:0]  tp_q [6];
	logic signed [2*TW-1:0]   dp_q [2];
	logic signed [PW-1:0]     num_q [3];
	logic [DETW-1:0]          den_q;
	logic [DETW-1:0]          rem_q;
	logic [DIVW-1:0]          dvd_q;
	logic [DIVW-1:0]          quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [1:0]               idx_q;
	logic                     neg_q;
	logic                     det_neg_q;
	logic signed [NORM_W-1:0] nrm_q [3];
	logic signed [TAN_W-1:0]  tg_q [3];
	logic                     degen_q;

	logic signed [DETW-1:0]   det;
	logic [DETW:0]            rem_sh;
	logic [DETW:0]            rem_sub;
	logic [DIVW-1:0]          q_rnd;
	logic [DIVW-1:0]          lim;
	logic [DETW-1:0]          det_mag;
	logic signed [PW-1:0]     num_sel;
	logic [PW-1:0]            num_mag;

	assign det     = DETW'(dp_q[0]) - DETW'(dp_q[1]);
	assign det_mag = det[DETW-1] ? DETW'(-det) : DETW'(det);
	assign rem_sh  = {rem_q, dvd_q[DIVW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_rnd   = (quo_q + DIVW'(1)) >> 1;
	assign lim     = DIVW'(1) << (TAN_W - 1);
	assign num_sel = num_q[idx_q];
	assign num_mag = num_sel[PW-1] ? PW'(-num_sel) : PW'(num_sel);

	assign q_ready = (state_q == S_IDLE);

	assign res.valid         = (state_q == S_OUT);
	assign res.normal_x      = nrm_q[0];
	assign res.normal_y      = nrm_q[1];
	assign res.normal_z      = nrm_q[2];
	assign res.tangent_x     = tg_q[0];
	assign res.tangent_y     = tg_q[1];
	assign res.tangent_z     = tg_q[2];
	assign res.degenerate_uv = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
			cnt_q   <= '0;
			degen_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						b_q[0] <= DW'(q_data.p1.x) - DW'(q_data.p0.x);
						b_q[1] <= DW'(q_data.p1.y) - DW'(q_data.p0.y);
						b_q[2] <= DW'(q_data.p1.z) - DW'(q_data.p0.z);
						a_q[0] <= DW'(q_data.p2.x) - DW'(q_data.p0.x);
						a_q[1] <= DW'(q_data.p2.y) - DW'(q_data.p0.y);
						a_q[2] <= DW'(q_data.p2.z) - DW'(q_data.p0.z);
						du1_q  <= TW'(q_data.t1.u) - TW'(q_data.t0.u);
						dv1_q  <= TW'(q_data.t1.v) - TW'(q_data.t0.v);
						du2_q  <= TW'(q_data.t2.u) - TW'(q_data.t0.u);
						dv2_q  <= TW'(q_data.t2.v) - TW'(q_data.t0.v);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					np_q[0] <= b_q[1] * a_q[2];
					np_q[1] <= b_q[2] * a_q[1];
					np_q[2] <= b_q[2] * a_q[0];
					np_q[3] <= b_q[0] * a_q[2];
					np_q[4] <= b_q[0] * a_q[1];
					np_q[5] <= b_q[1] * a_q[0];
					tp_q[0] <= b_q[0] * dv2_q;
					tp_q[1] <= a_q[0] * dv1_q;
					tp_q[2] <= b_q[1] * dv2_q;
					tp_q[3] <= a_q[1] * dv1_q;
					tp_q[4] <= b_q[2] * dv2_q;
					tp_q[5] <= a_q[2] * dv1_q;
					dp_q[0] <= du1_q * dv2_q;
					dp_q[1] <= dv1_q * du2_q;
					state_q <= S_SUB;
				end
				S_SUB: begin
					for (int i = 0; i < 3; i++) begin
						nrm_q[i] <= normal_en ?
							sat_norm(NPW'(np_q[2*i]) - NPW'(np_q[2*i+1])) : '0;
						num_q[i] <= PW'(tp_q[2*i]) - PW'(tp_q[2*i+1]);
						tg_q[i]  <= '0;
					end
					den_q     <= det_mag;
					det_neg_q <= det[DETW-1];
					degen_q   <= tangent_en && (det == '0);
					idx_q     <= 2'd0;
					if (tangent_en && det != '0)
						state_q <= S_LOAD;
					else
						state_q <= S_OUT;
				end
				S_LOAD: begin
					dvd_q   <= DIVW'(num_mag) << (UV_FRAC + 1);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CNT_W'(DIVW);
					neg_q   <= num_sel[PW-1] ^ det_neg_q;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_sub[DETW]) begin
						rem_q <= DETW'(rem_sh);
						quo_q <= {quo_q[DIVW-2:0], 1'b0};
					end else begin
						rem_q <= DETW'(rem_sub);
						quo_q <= {quo_q[DIVW-2:0], 1'b1};
					end
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (neg_q)
						tg_q[idx_q] <= (q_rnd >= lim) ? TAN_W'(-lim) : TAN_W'(-q_rnd);
					else
						tg_q[idx_q] <= (q_rnd > lim - DIVW'(1)) ?
							TAN_W'(lim - DIVW'(1)) : TAN_W'(q_rnd);
					if (idx_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_OUT: begin
					if (res.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/triangle_normal_tangent_unit.sv */
// Triangle normal / UV tangent unit.
// vtx: one vertex request per accepted cycle (position Q7.8, texcoord Q3.12, restart).
//   Every third vertex since reset or restart completes a triangle; restart drops a
//   partly assembled one. Vertices are taken one per cycle while the two-entry
//   triangle queue has room.
// res: one result per triangle, held until res.ready; vertices are still taken while the queue has room.
// cfg: index 0 normal enable, index 1 tangent enable, bit 0 of data; always ready.
//   Write only while the unit is idle.
// Path: after the third vertex a triangle passes the queue, S_IDLE, S_MUL and S_SUB to
//   S_OUT when the tangent is off or degenerate; otherwise, before S_OUT, the shared 48-step
//   radix-2 divider serves the three tangent components in turn (load, 48 steps, store).
// The back end takes the next triangle only after res.ready accepts the current result.
// Reset: both enables on, vertex slot cleared, queue empty, no result pending.
module triangle_normal_tangent_unit (
	input  logic      clk,
	input  logic      arst_n,
	tnt_vtx_if.sink   vtx,
	tnt_cfg_if.sink   cfg,
	tnt_res_if.source res
);
	import tnt_pkg::*;

	logic normal_en_q;
	logic tangent_en_q;
	logic f_valid, f_ready, b_valid, b_ready;
	tri_t f_data, b_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_en_q  <= 1'b1;
			tangent_en_q <= 1'b1;
		end else if (cfg.valid) begin
			if (cfg.index == REG_NORMAL_EN)
				normal_en_q <= cfg.data[0];
			else if (cfg.index == REG_TANGENT_EN)
				tangent_en_q <= cfg.data[0];
		end
	end

	tnt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx),
		.q_valid (f_valid),
		.q_ready (f_ready),
		.q_data  (f_data)
	);

	tnt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	tnt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.normal_en  (normal_en_q),
		.tangent_en (tangent_en_q),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.q_data     (b_data),
		.res        (res)
	);
endmodule
